### hdl/fra_pkg.sv
// Shared types and constants for the fragment reassembler.
package fra_pkg;

  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned POS_W     = 9;     // frame position, saturates at HDR_BYTES + 255
  localparam int unsigned POS_MAX   = HDR_BYTES + 255;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_AW      = $clog2(Q_DEPTH);
  localparam int unsigned IN_DW     = 64;
  localparam int unsigned OUT_DW    = 72;

  typedef enum logic [2:0] {
    EV_READ      = 3'd0,
    EV_ACCEPT    = 3'd1,
    EV_COMPLETE  = 3'd2,
    EV_OVERFLOW  = 3'd3,
    EV_ORDER     = 3'd4,
    EV_SHORT     = 3'd5,
    EV_TRUNCATED = 3'd6
  } ev_t;

  // One classified item, as handed from front to back.
  typedef struct packed {
    logic        is_read;
    logic        hdr_last;   // last header byte: qualify the fragment
    logic        pay_wr;     // payload byte inside the declared length
    logic        is_end;
    logic        short_f;    // frame ended inside the header
    logic        got_lt;     // fewer payload bytes than declared
    logic [7:0]  off;
    logic [7:0]  data_byte;
    logic [7:0]  h_id;
    logic [7:0]  h_idx;
    logic [7:0]  h_cnt;
    logic [7:0]  h_len;
    logic [47:0] src;
    logic [7:0]  ridx;
  } fra_item_t;

endpackage

### hdl/fra_front.sv
// Front end: tracks frame position, captures the header and classifies each item.
module fra_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              opcode,
  input  logic [7:0]        frame_byte,
  input  logic              frame_end,
  input  logic [47:0]       source_address,
  input  logic [7:0]        read_index,
  output fra_pkg::fra_item_t item
);
  import fra_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc, got;
  logic [7:0] id_r, idx_r, cnt_r, len_r;
  logic [7:0] id_nxt, idx_nxt, cnt_nxt, len_nxt;
  logic       in_hdr;

  assign in_hdr  = pos_r < POS_W'(HDR_BYTES);
  assign pos_inc = (pos_r < POS_W'(POS_MAX)) ? pos_r + 1'b1 : pos_r;
  assign got     = pos_inc - POS_W'(HDR_BYTES);

  always_comb begin
    id_nxt  = id_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    len_nxt = len_r;
    if (in_hdr) begin
      case (pos_r[1:0])
        2'd0:    id_nxt  = frame_byte;
        2'd1:    idx_nxt = frame_byte;
        2'd2:    cnt_nxt = frame_byte;
        default: len_nxt = frame_byte;
      endcase
    end
    pos_nxt = frame_end ? '0 : pos_inc;
  end

  always_comb begin
    item.is_read   = opcode;
    item.hdr_last  = pos_r == POS_W'(HDR_BYTES - 1);
    item.off       = 8'(pos_r - POS_W'(HDR_BYTES));
    item.pay_wr    = !in_hdr && (item.off < len_r);
    item.is_end    = frame_end;
    item.short_f   = pos_inc < POS_W'(HDR_BYTES);
    item.got_lt    = got < POS_W'(len_nxt);
    item.data_byte = frame_byte;
    item.h_id      = id_nxt;
    item.h_idx     = idx_nxt;
    item.h_cnt     = cnt_nxt;
    item.h_len     = len_nxt;
    item.src       = source_address;
    item.ridx      = read_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      id_r  <= '0;
      idx_r <= '0;
      cnt_r <= '0;
      len_r <= '0;
    end else if (accept && !opcode) begin
      pos_r <= pos_nxt;
      id_r  <= id_nxt;
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

### hdl/fra_queue.sv
// Small FIFO of classified items between front and back.
module fra_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fra_pkg::fra_item_t push_item,
  input  logic               pop,
  output fra_pkg::fra_item_t head,
  output logic               empty,
  output logic               full
);
  import fra_pkg::*;

  fra_item_t      slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r;

  assign empty = cnt_r == '0;
  assign full  = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### hdl/fra_back.sv
// Back end: reassembly state, message store and the registered result.
module fra_back #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  fra_pkg::fra_item_t it,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output fra_pkg::ev_t       ev,
  output logic [8:0]         msg_len,
  output logic [47:0]        sender,
  output logic [7:0]         rd_byte
);
  import fra_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned LW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned SW = ((LW > 9) ? LW : 9) + 1;
  localparam int unsigned RW = ((AW > 8) ? AW : 8) + 1;

  logic [7:0]    mem [BUFFER_BYTES];
  logic [7:0]    rd_r;
  logic          rd_zero_r;

  logic [LW-1:0] asm_r, asm_nxt;
  logic [7:0]    exp_r, exp_nxt, cur_r, cur_nxt;
  logic          fv_r, fv_nxt;

  logic          ov_r;
  ev_t           ev_r, ev_nxt;
  logic [8:0]    len_r, len_nxt;
  logic [47:0]   snd_r, snd_nxt;
  logic          has_res;

  logic          restart;
  logic [LW-1:0] base;
  logic [SW-1:0] wr_at, fit_sum, end_sum;
  logic [7:0]    cur_eff, exp_eff, exp_inc;
  logic [LW-1:0] asm_eff;
  logic          seq_ok, we, in_range;
  logic [RW-1:0] ridx_w;

  assign pop     = q_valid && (!ov_r || out_ready);
  assign restart = it.h_idx == 8'd0;
  assign base    = restart ? '0 : asm_r;
  assign wr_at   = SW'(base) + SW'(it.off);
  assign fit_sum = SW'(base) + SW'(it.h_len);
  assign seq_ok  = restart || (it.h_id == cur_r && it.h_idx == exp_r);

  assign we      = pop && !it.is_read && fv_r && it.pay_wr && (wr_at < SW'(BUFFER_BYTES));
  assign ridx_w  = RW'(it.ridx);
  assign in_range = ridx_w < RW'(BUFFER_BYTES);

  // Header restart folds into the end-of-frame checks
  assign cur_eff = restart ? it.h_id : cur_r;
  assign exp_eff = restart ? 8'd0 : exp_r;
  assign asm_eff = restart ? '0 : asm_r;
  assign end_sum = SW'(asm_eff) + SW'(it.h_len);
  assign exp_inc = exp_eff + 8'd1;

  always_comb begin
    asm_nxt = asm_r;
    exp_nxt = exp_r;
    cur_nxt = cur_r;
    fv_nxt  = fv_r;
    ev_nxt  = EV_READ;
    len_nxt = '0;
    snd_nxt = '0;
    has_res = 1'b0;
    if (it.is_read) begin
      has_res = 1'b1;
    end else begin
      if (it.hdr_last) fv_nxt = seq_ok && (fit_sum <= SW'(BUFFER_BYTES));
      if (it.is_end) begin
        fv_nxt  = 1'b0;
        has_res = 1'b1;
        if (it.short_f) begin
          ev_nxt = EV_SHORT;
        end else begin
          cur_nxt = cur_eff;
          exp_nxt = exp_eff;
          asm_nxt = '0;
          if (it.h_id != cur_eff || it.h_idx != exp_eff) begin
            ev_nxt = EV_ORDER;
          end else if (end_sum > SW'(BUFFER_BYTES)) begin
            ev_nxt = EV_OVERFLOW;
          end else if (it.got_lt) begin
            ev_nxt = EV_TRUNCATED;
          end else begin
            exp_nxt = exp_inc;
            if (exp_inc == it.h_cnt) begin
              ev_nxt  = EV_COMPLETE;
              len_nxt = end_sum[8:0];
              snd_nxt = it.src;
            end else begin
              ev_nxt  = EV_ACCEPT;
              asm_nxt = end_sum[LW-1:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_at[AW-1:0]] <= it.data_byte;
    if (pop && it.is_read) begin
      rd_r      <= mem[ridx_w[AW-1:0]];
      rd_zero_r <= !in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_res) begin
      ev_r  <= ev_nxt;
      len_r <= len_nxt;
      snd_r <= snd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_r <= '0;
      exp_r <= '0;
      cur_r <= '0;
      fv_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      if (pop) begin
        asm_r <= asm_nxt;
        exp_r <= exp_nxt;
        cur_r <= cur_nxt;
        fv_r  <= fv_nxt;
      end
      if (pop && has_res) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  assign out_valid = ov_r;
  assign ev        = ev_r;
  assign msg_len   = len_r;
  assign sender    = snd_r;
  assign rd_byte   = (ev_r == EV_READ && !rd_zero_r) ? rd_r : 8'd0;

endmodule

### hdl/fragment_reassembler_core.sv
// Top level of the fragment reassembler: front, item queue and back.
//
//  channel | dir | tdata (low bit up)                       | tuser       | tlast
//  in_     | in  | frame_byte, source_address, read_index   | opcode      | frame_end
//  out_    | out | message_length, sender_address, read_data| event_res   | -
//
//  One item per cycle sustained; the front only stalls when the 4-entry queue is full.
//  From in to out an item passes the queue register, then the result register, which
//  also holds the registered store read for read items.
//  A stalled result blocks the back only; the queue absorbs up to 4 more items.
//  rst_n is synchronous; the message store is not cleared and needs no sweep.
module fragment_reassembler_core #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [fra_pkg::IN_DW-1:0]  in_tdata,   // frame_byte[7:0], source_address[55:8], read_index[63:56]
  input  logic [0:0]                 in_tuser,   // opcode[0]
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [fra_pkg::OUT_DW-1:0] out_tdata,  // message_length[8:0], sender_address[56:9], read_data[64:57]
  output logic [2:0]                 out_tuser   // event_res[2:0]
);
  import fra_pkg::*;

  fra_item_t  fe_item, q_head;
  logic       q_empty, q_full, q_pop, acc;
  ev_t        ev;
  logic [8:0] msg_len;
  logic [47:0] sender;
  logic [7:0] rd_byte;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && !q_full;

  fra_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (acc),
    .opcode         (in_tuser[0]),
    .frame_byte     (in_tdata[7:0]),
    .frame_end      (in_tlast),
    .source_address (in_tdata[55:8]),
    .read_index     (in_tdata[63:56]),
    .item           (fe_item)
  );

  fra_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_item (fe_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  fra_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_empty),
    .it        (q_head),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .ev        (ev),
    .msg_len   (msg_len),
    .sender    (sender),
    .rd_byte   (rd_byte)
  );

  assign out_tuser = ev;
  assign out_tdata = {7'd0, rd_byte, sender, msg_len};

endmodule

### hdl/fra_checker.sv
// Port-level checks for the fragment reassembler, bound to the top level.
module fra_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [fra_pkg::OUT_DW-1:0] out_tdata,
  input logic [2:0]                 out_tuser
);
  import fra_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // length and sender only carry data for a completed message
  a_cpl_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_COMPLETE |-> out_tdata[56:0] == '0)
    else $error("length or sender set on a non-complete event");

  a_rd_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_READ |-> out_tdata[64:57] == '0)
    else $error("read data set on a frame event");

endmodule

bind fragment_reassembler_core fra_checker u_fra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
